FILE: rtl/mu8r_pkg.sv
// shared types and constants of the modified utf-8 repair stream unit
`default_nettype none

package mu8r_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MASK7     = 2'd0;
  localparam logic [1:0] CFG_BSL_STOP  = 2'd1;
  localparam logic [1:0] CFG_MAX_CHARS = 2'd2;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // byte codes
  localparam logic [7:0] BYTE_ZERO_LEAD = 8'b11000000;
  localparam logic [7:0] BYTE_CONT      = 8'b10000000;
  localparam logic [7:0] BYTE_E0        = 8'b11100000;
  localparam logic [7:0] BYTE_ED        = 8'b11101101;
  localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
  localparam logic [7:0] ASCII_MASK     = 8'h7F;
  localparam logic [7:0] LOW_LEAD_MASK  = 8'b00011110;

  // longest burst a single byte can release (surrogate pair)
  localparam int MAX_BURST   = 6;
  localparam int BURST_BITS  = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int REPORT_BITS = 16;

  typedef struct packed {
    logic                   mask7;
    logic                   bsl_stop;
    logic [REPORT_BITS-1:0] max_chars;
  } cfg_t;

  // one burst of results released by one input byte
  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [BURST_BITS-1:0]     nbytes;
    logic                      last;
    logic [REPORT_BITS-1:0]    consumed;
    logic [REPORT_BITS-1:0]    chars;
  } rec_t;

endpackage

`default_nettype wire

FILE: rtl/mu8r_front.sv
// front end: byte classifier, repair state machine, held bytes and run counters
`default_nettype none

module mu8r_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mu8r_pkg::cfg_t cfg,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_data,
  output logic               rec_push,
  output mu8r_pkg::rec_t     rec
);

  localparam int CW  = (COUNT_BITS > mu8r_pkg::REPORT_BITS) ? COUNT_BITS
                                                            : mu8r_pkg::REPORT_BITS;
  localparam int NPEND = mu8r_pkg::MAX_BURST - 1;

  typedef enum logic [3:0] {
    ST_LEAD            = 4'd0,
    ST_AFTER_BSL       = 4'd1,
    ST_CONT            = 4'd2,
    ST_CONT_LOWLEAD    = 4'd3,
    ST_FIRST_LOWLEAD   = 4'd4,
    ST_FIRST_SURR      = 4'd5,
    ST_FIRST           = 4'd6,
    ST_SECOND          = 4'd7,
    ST_LEAD_LOWSURR    = 4'd8,
    ST_FIRST_LOWSURR   = 4'd9,
    ST_SECOND_HIGHSURR = 4'd10,
    ST_SECOND_LOWSURR  = 4'd11
  } state_t;

  state_t                state, state_next;
  logic [7:0]            pending [NPEND];
  logic [2:0]            pcount, pcount_next;
  logic [COUNT_BITS-1:0] char_cnt, char_cnt_next;
  logic [COUNT_BITS-1:0] byte_cnt, byte_cnt_next;
  logic                  run_finished, run_finished_next;
  logic                  pend_we;
  logic [7:0]            pend_wdata;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [mu8r_pkg::REPORT_BITS-1:0] clip(
      input logic [COUNT_BITS-1:0] v);
    logic [CW-1:0] wide;
    wide = CW'(v);
    clip = (wide > CW'({mu8r_pkg::REPORT_BITS{1'b1}})) ? {mu8r_pkg::REPORT_BITS{1'b1}}
                                                       : wide[mu8r_pkg::REPORT_BITS-1:0];
  endfunction

  function automatic logic at_limit(input logic [COUNT_BITS-1:0] v,
                                    input logic [mu8r_pkg::REPORT_BITS-1:0] lim);
    at_limit = CW'(v) >= CW'(lim);
  endfunction

  function automatic logic [7:0] cont(input logic [7:0] b);
    cont = {2'b10, b[5:0]};
  endfunction

  always_comb begin
    logic [7:0]            c;
    logic [7:0]            c2;
    logic [7:0]            p0;
    state_t                st_n;
    state_t                fin_state;
    logic                  append;
    logic                  char_inc;
    logic                  ins_zero;
    logic                  fix_lead;
    logic                  bsl_end;
    logic                  finish;
    logic                  emit;
    logic [COUNT_BITS-1:0] char_after;
    logic [COUNT_BITS-1:0] byte_after;
    logic [COUNT_BITS-1:0] char_rep;
    logic [7:0]            work [mu8r_pkg::MAX_BURST];

    state_next        = state;
    pcount_next       = pcount;
    char_cnt_next     = char_cnt;
    byte_cnt_next     = byte_cnt;
    run_finished_next = run_finished;
    pend_we           = 1'b0;
    pend_wdata        = 8'h00;
    rec_push          = 1'b0;
    rec               = '0;

    c          = cfg.mask7 ? (data_byte & mu8r_pkg::ASCII_MASK) : data_byte;
    c2         = c;
    st_n       = state;
    fin_state  = state;
    append     = 1'b1;
    char_inc   = 1'b0;
    ins_zero   = 1'b0;
    fix_lead   = 1'b0;
    bsl_end    = 1'b0;
    finish     = 1'b0;
    emit       = 1'b0;
    byte_after = sat_inc(byte_cnt);
    char_after = char_cnt;
    char_rep   = char_cnt;
    p0         = pending[0];
    for (int k = 0; k < mu8r_pkg::MAX_BURST; k++) work[k] = 8'h00;

    unique case (state)
      ST_AFTER_BSL: begin
        if (c != mu8r_pkg::BYTE_BACKSLASH) begin
          bsl_end = 1'b1;
        end else begin
          st_n     = ST_LEAD;
          char_inc = 1'b1;
        end
      end
      ST_CONT_LOWLEAD: begin
        c2 = cont(c);
        fix_lead = (pcount != 3'd0) &&
                   !(pending[0] == mu8r_pkg::BYTE_ZERO_LEAD && c2 == mu8r_pkg::BYTE_CONT);
        st_n     = ST_LEAD;
        char_inc = 1'b1;
      end
      ST_CONT: begin
        c2 = cont(c);
        st_n     = ST_LEAD;
        char_inc = 1'b1;
      end
      ST_FIRST_LOWLEAD: begin
        c2   = cont(c) | 8'h20;
        st_n = ST_SECOND;
      end
      ST_FIRST_SURR: begin
        c2 = cont(c);
        if (c2[5]) begin
          c2[4] = 1'b0;
          st_n  = ST_SECOND_HIGHSURR;
        end else begin
          st_n = ST_SECOND;
        end
      end
      ST_FIRST: begin
        c2   = cont(c);
        st_n = ST_SECOND;
      end
      ST_SECOND_HIGHSURR: begin
        c2       = cont(c);
        st_n     = ST_LEAD_LOWSURR;
        char_inc = 1'b1;
      end
      ST_LEAD_LOWSURR: begin
        c2   = mu8r_pkg::BYTE_ED;
        st_n = ST_FIRST_LOWSURR;
      end
      ST_FIRST_LOWSURR: begin
        c2   = cont(c) | 8'h30;
        st_n = ST_SECOND_LOWSURR;
      end
      ST_SECOND, ST_SECOND_LOWSURR: begin
        c2       = cont(c);
        st_n     = ST_LEAD;
        char_inc = 1'b1;
      end
      default: begin
        // generic leading byte
        priority if (!c[7]) begin
          if (c == 8'h00) begin
            ins_zero = 1'b1;
            c2       = mu8r_pkg::BYTE_CONT;
            char_inc = 1'b1;
            st_n     = ST_LEAD;
          end else if (cfg.bsl_stop && c == mu8r_pkg::BYTE_BACKSLASH) begin
            st_n   = ST_AFTER_BSL;
            append = 1'b0;
          end else begin
            char_inc = 1'b1;
            st_n     = ST_LEAD;
          end
        end else if (!c[5] || !c[6]) begin
          // one or two leading ones: force a two-byte leader
          if (!c[6]) c2 = {3'b110, c[4:0]};
          st_n = ((c2 & mu8r_pkg::LOW_LEAD_MASK) == 8'h00) ? ST_CONT_LOWLEAD : ST_CONT;
        end else begin
          if (c[4]) c2[4] = 1'b0;
          if (c2 == mu8r_pkg::BYTE_E0)      st_n = ST_FIRST_LOWLEAD;
          else if (c2 == mu8r_pkg::BYTE_ED) st_n = ST_FIRST_SURR;
          else                              st_n = ST_FIRST;
        end
      end
    endcase

    if (fix_lead) p0 = pending[0] | 8'h02;
    char_after = char_inc ? sat_inc(char_cnt) : char_cnt;

    if (take) begin
      if (run_finished) begin
        if (end_of_data) run_finished_next = 1'b0;
      end else if (at_limit(char_cnt, cfg.max_chars)) begin
        // limit reached before this byte: byte not consumed
        finish    = 1'b1;
        fin_state = state;
        char_rep  = char_cnt;
        byte_after = byte_cnt;
      end else if (bsl_end) begin
        finish    = 1'b1;
        fin_state = ST_AFTER_BSL;
        char_rep  = char_cnt;
      end else begin
        emit = (st_n == ST_LEAD);
        for (int k = 0; k < mu8r_pkg::MAX_BURST; k++) begin
          if (k == 0 && pcount != 3'd0)          work[k] = p0;
          else if (k > 0 && k < NPEND && 3'(k) < pcount) work[k] = pending[k];
          else if (3'(k) == pcount)              work[k] = ins_zero ? mu8r_pkg::BYTE_ZERO_LEAD
                                                                    : c2;
          else if (3'(k) == pcount + 3'd1 && ins_zero) work[k] = c2;
        end
        if (emit) begin
          rec.nbytes  = pcount + 3'd1 + {2'b00, ins_zero};
          pcount_next = 3'd0;
        end else if (append) begin
          pend_we     = 1'b1;
          pend_wdata  = c2;
          pcount_next = pcount + 3'd1;
        end
        for (int k = 0; k < mu8r_pkg::MAX_BURST; k++) rec.bytes[k] = work[k];
        state_next    = st_n;
        char_cnt_next = char_after;
        char_rep      = char_after;
        fin_state     = st_n;
        finish        = end_of_data || at_limit(char_after, cfg.max_chars);
        if (finish) pend_we = 1'b0;
      end

      if (!run_finished) byte_cnt_next = byte_after;

      if (finish) begin
        // a dropped high surrogate gives back its character
        if ((fin_state == ST_LEAD_LOWSURR || fin_state == ST_FIRST_LOWSURR ||
             fin_state == ST_SECOND_LOWSURR) && char_rep != '0) begin
          char_rep = char_rep - 1'b1;
        end
        rec.last          = 1'b1;
        rec.consumed      = clip(byte_after);
        rec.chars         = clip(char_rep);
        state_next        = ST_LEAD;
        pcount_next       = 3'd0;
        char_cnt_next     = '0;
        byte_cnt_next     = '0;
        run_finished_next = !end_of_data;
      end
      rec_push = finish || (rec.nbytes != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LEAD;
      pcount       <= 3'd0;
      char_cnt     <= '0;
      byte_cnt     <= '0;
      run_finished <= 1'b0;
    end else begin
      state        <= state_next;
      pcount       <= pcount_next;
      char_cnt     <= char_cnt_next;
      byte_cnt     <= byte_cnt_next;
      run_finished <= run_finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) pending[pcount] <= pend_wdata;
  end

endmodule

`default_nettype wire

FILE: rtl/mu8r_queue.sv
// short burst queue between the front end and the output sequencer
`default_nettype none

module mu8r_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire mu8r_pkg::rec_t wdata,
  input  wire logic           rd,
  output mu8r_pkg::rec_t      rdata,
  output logic                full,
  output logic                empty
);

  localparam int PW = $clog2(mu8r_pkg::QUEUE_DEPTH);

  mu8r_pkg::rec_t   slots [mu8r_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [PW:0]      fill;

  assign full  = (fill == (PW+1)'(mu8r_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == PW'(mu8r_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd) rd_ptr <= (rd_ptr == PW'(mu8r_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({wr, rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

FILE: rtl/mu8r_back.sv
// output sequencer: splits each burst into single results behind an output register
`default_nettype none

module mu8r_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire mu8r_pkg::rec_t q_rec,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                has_byte,
  output logic                end_of_string,
  output logic [15:0]         bytes_consumed,
  output logic [15:0]         chars_produced
);

  mu8r_pkg::rec_t                  cur;
  logic                            cur_valid;
  logic [mu8r_pkg::BURST_BITS-1:0] idx;
  logic [mu8r_pkg::BURST_BITS-1:0] nres;
  logic                            out_valid;
  logic                            slot_free;
  logic                            emit;
  logic                            cur_done;
  logic                            is_last;

  assign nres      = (cur.nbytes == '0) ? mu8r_pkg::BURST_BITS'(1) : cur.nbytes;
  assign slot_free = !out_valid || pop;
  assign emit      = slot_free && cur_valid;
  assign is_last   = (idx == nres - 1'b1);
  assign cur_done  = emit && is_last;
  assign q_pop     = !q_empty && (!cur_valid || cur_done);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (slot_free) out_valid <= cur_valid;
      if (emit) idx <= is_last ? '0 : idx + 1'b1;
      if (q_pop)         cur_valid <= 1'b1;
      else if (cur_done) cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_rec;
    if (emit) begin
      has_byte       <= (cur.nbytes != '0);
      out_byte       <= (cur.nbytes != '0) ? cur.bytes[idx] : 8'h00;
      end_of_string  <= cur.last && is_last;
      bytes_consumed <= (cur.last && is_last) ? cur.consumed : 16'h0000;
      chars_produced <= (cur.last && is_last) ? cur.chars : 16'h0000;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/modified_utf8_repair_stream_unit.sv
// top level of the modified utf-8 repair stream unit
`default_nettype none

// Rewrites a run of raw bytes into valid modified UTF-8 (CESU-8 form, zero
// character as C0 80). Bytes enter through a queue-style port (push/full) at
// one byte per clock; the front end classifies and repairs each byte in that
// same cycle and holds the bytes of an unfinished character. When a character
// completes its bytes (up to six for a surrogate pair) move as one burst into
// a four-deep queue, and the output side hands them out one result per clock
// through an output register (empty/pop) while results are popped. The
// sustained rate is one input byte per cycle, bounded by the output side at
// one result per cycle; a zero byte yields two results, so zero runs are
// output-bound. full rises only when four bursts wait. The run ends on a byte
// marked end_of_data, when max_chars characters have been produced, or on a
// lone backslash in backslash stop mode; the last result carries
// end_of_string and the clipped byte and character counts, and is a bare
// marker (has_byte low) when no byte goes with it. Configuration writes
// (cfg_write, cfg_index, cfg_data) take effect at once and should only be
// made while the unit is idle. There is no clearing pass after reset.
module modified_utf8_repair_stream_unit #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_data,
  // result output
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic             end_of_string,
  output logic [15:0]      bytes_consumed,
  output logic [15:0]      chars_produced,
  // configuration writes
  input  wire logic        cfg_write,
  input  wire logic [mu8r_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [mu8r_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  mu8r_pkg::cfg_t cfg;
  mu8r_pkg::rec_t f_rec;
  mu8r_pkg::rec_t q_rec;
  logic           f_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           take;

  // a transaction on the input side
  assign take = push && !full;
  assign full = q_full;

  // configuration registers; writes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask7     <= 1'b0;
      cfg.bsl_stop  <= 1'b0;
      cfg.max_chars <= 16'hFFFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mu8r_pkg::CFG_MASK7:     cfg.mask7     <= cfg_data[0];
        mu8r_pkg::CFG_BSL_STOP:  cfg.bsl_stop  <= cfg_data[0];
        mu8r_pkg::CFG_MAX_CHARS: cfg.max_chars <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: repair state machine, held bytes, counters
  mu8r_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .rec_push    (f_push),
    .rec         (f_rec)
  );

  // bursts wait here so that either side may stall alone
  mu8r_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_push),
    .wdata (f_rec),
    .rd    (q_pop),
    .rdata (q_rec),
    .full  (q_full),
    .empty (q_empty)
  );

  // output side: one result per transaction
  mu8r_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_rec          (q_rec),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .end_of_string  (end_of_string),
    .bytes_consumed (bytes_consumed),
    .chars_produced (chars_produced)
  );

endmodule

`default_nettype wire

FILE: rtl/mu8r_checker.sv
// port-level checks of the repair stream unit and their bind
`default_nettype none

module mu8r_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  out_byte,
  input wire logic        has_byte,
  input wire logic        end_of_string,
  input wire logic [15:0] bytes_consumed,
  input wire logic [15:0] chars_produced
);

  // nothing waits on the output right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(end_of_string)))
    else $error("stalled result changed");

  // a bare marker only ends a string and carries no byte
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    (!empty && !has_byte) |-> (end_of_string && out_byte == 8'h00))
    else $error("bare marker without end of string");

  // counts are shown only on the final result
  a_counts_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !end_of_string) |-> (bytes_consumed == 16'h0000 && chars_produced == 16'h0000))
    else $error("counts on a non-final result");

endmodule

bind modified_utf8_repair_stream_unit mu8r_checker u_mu8r_checker (
  .clk            (clk),
  .rst            (rst),
  .empty          (empty),
  .pop            (pop),
  .out_byte       (out_byte),
  .has_byte       (has_byte),
  .end_of_string  (end_of_string),
  .bytes_consumed (bytes_consumed),
  .chars_produced (chars_produced)
);

`default_nettype wire
